### design/rdi_pkg.sv
package rdi_pkg;

    localparam int DW         = 32;
    localparam int LIM_W      = 31;
    localparam int MDZ_W      = 17;
    localparam int CFG_IW     = 3;
    localparam int CFG_DW     = 64;
    localparam int SQRT_STEPS = 32;

    localparam logic [CFG_IW-1:0] CFG_R0C01 = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_R0C23 = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_R1C01 = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_R1C23 = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_R2C01 = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_R2C23 = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_MDZ   = 3'd6;

    // three components of a vector, 32 bits each
    typedef logic [2:0][DW-1:0] vec_t;
    // inverse matrix entries, row r column c at r*4+c
    typedef logic [11:0][DW-1:0] mat_t;

endpackage

### design/rdi_wmul.sv
module rdi_wmul
    import rdi_pkg::*;
#(
    parameter int AW = 49,
    parameter int BW = 32
)
(
    input  logic             clk,
    input  logic             adv,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [PW-1:0]    p_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ll_reg <= a[AL-1:0] * b[BL-1:0];
            lh_reg <= a[AL-1:0] * b[BW-1:BL];
            hl_reg <= a[AW-1:AL] * b[BL-1:0];
            hh_reg <= a[AW-1:AL] * b[BW-1:BL];
            p_reg  <= PW'(ll_reg) + (PW'(lh_reg) << BL) + (PW'(hl_reg) << AL)
                    + (PW'(hh_reg) << (AL + BL));
        end
    end

    assign p = p_reg;

endmodule

### design/rdi_xform.sv
module rdi_xform
    import rdi_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int LW        = 50,
    parameter int TQW       = 49
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  vec_t                 o,
    input  vec_t                 d,
    input  logic [LIM_W-1:0]     near_l,
    input  logic [LIM_W-1:0]     far_l,
    input  mat_t                 m,
    input  logic [MDZ_W-1:0]     mdz,
    output logic                 out_valid,
    output logic signed [LW-1:0] lo0,
    output logic signed [LW-1:0] lo1,
    output logic signed [LW-1:0] ld0,
    output logic signed [LW-1:0] ld1,
    output logic [LW-1:0]        az,
    output logic [LW-1:0]        rem0,
    output logic [TQW-1:0]       numlo,
    output logic [63:0]          sq,
    output logic                 miss,
    output vec_t                 o_q,
    output vec_t                 d_q,
    output logic [LIM_W-1:0]     near_q,
    output logic [LIM_W-1:0]     far_q
);

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [63:0]   po_reg [3][3];
    logic signed [63:0]   pd_reg [3][3];
    logic [63:0]          sqd_reg [3];
    vec_t                 o1_reg, o2_reg, o3_reg, d1_reg, d2_reg, d3_reg;
    logic [LIM_W-1:0]     n1_reg, n2_reg, n3_reg, f1_reg, f2_reg, f3_reg;
    logic signed [LW-1:0] lo_reg [3];
    logic signed [LW-1:0] ld_reg [3];
    logic [63:0]          sq2_reg, sq3_reg;
    logic signed [LW-1:0] lo0_reg, lo1_reg, ld0_reg, ld1_reg;
    logic [LW-1:0]        az_reg, rem0_reg;
    logic [TQW-1:0]       numlo_reg;
    logic                 miss_reg;

    logic [DW-1:0]        dm [3];
    logic signed [65:0]   so [3];
    logic signed [65:0]   sd [3];
    logic signed [LW-1:0] lo_next [3];
    logic signed [LW-1:0] ld_next [3];
    logic [LW-1:0]        az_next, al_next, rem0_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dm[c] = d[c][DW-1] ? (~d[c] + 32'd1) : d[c];
        end
        for (int r = 0; r < 3; r++)
        begin
            so[r] = 66'(po_reg[r][0]) + 66'(po_reg[r][1]) + 66'(po_reg[r][2]);
            sd[r] = 66'(pd_reg[r][0]) + 66'(pd_reg[r][1]) + 66'(pd_reg[r][2]);
            lo_next[r] = LW'(so[r] >>> FRAC_BITS) + LW'($signed(m[r*4+3]));
            ld_next[r] = LW'(sd[r] >>> FRAC_BITS);
        end
        az_next   = ld_reg[2][LW-1] ? LW'(-ld_reg[2]) : LW'(ld_reg[2]);
        al_next   = lo_reg[2][LW-1] ? LW'(-lo_reg[2]) : LW'(lo_reg[2]);
        rem0_next = al_next >> (TQW - FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    po_reg[r][c] <= $signed(m[r*4+c]) * $signed(o[c]);
                    pd_reg[r][c] <= $signed(m[r*4+c]) * $signed(d[c]);
                end
                sqd_reg[r] <= dm[r] * dm[r];
                lo_reg[r]  <= lo_next[r];
                ld_reg[r]  <= ld_next[r];
            end
            o1_reg <= o;
            d1_reg <= d;
            n1_reg <= near_l;
            f1_reg <= far_l;
            o2_reg <= o1_reg;
            d2_reg <= d1_reg;
            n2_reg <= n1_reg;
            f2_reg <= f1_reg;
            sq2_reg <= sqd_reg[0] + sqd_reg[1] + sqd_reg[2];
            o3_reg <= o2_reg;
            d3_reg <= d2_reg;
            n3_reg <= n2_reg;
            f3_reg <= f2_reg;
            sq3_reg <= sq2_reg;
            lo0_reg <= lo_reg[0];
            lo1_reg <= lo_reg[1];
            ld0_reg <= ld_reg[0];
            ld1_reg <= ld_reg[1];
            az_reg  <= az_next;
            rem0_reg  <= rem0_next;
            numlo_reg <= TQW'({al_next, {FRAC_BITS{1'b0}}});
            miss_reg  <= (ld_reg[2] == '0) || (az_next < LW'(mdz)) || (lo_reg[2] == '0)
                      || (lo_reg[2][LW-1] == ld_reg[2][LW-1]) || (rem0_next >= az_next);
        end
    end

    assign out_valid = v3_reg;
    assign lo0    = lo0_reg;
    assign lo1    = lo1_reg;
    assign ld0    = ld0_reg;
    assign ld1    = ld1_reg;
    assign az     = az_reg;
    assign rem0   = rem0_reg;
    assign numlo  = numlo_reg;
    assign sq     = sq3_reg;
    assign miss   = miss_reg;
    assign o_q    = o3_reg;
    assign d_q    = d3_reg;
    assign near_q = n3_reg;
    assign far_q  = f3_reg;

endmodule

### design/rdi_solve.sv
module rdi_solve
    import rdi_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int LW        = 50,
    parameter int TQW       = 49
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [LW-1:0] lo0,
    input  logic signed [LW-1:0] lo1,
    input  logic signed [LW-1:0] ld0,
    input  logic signed [LW-1:0] ld1,
    input  logic [LW-1:0]        az,
    input  logic [LW-1:0]        rem0,
    input  logic [TQW-1:0]       numlo,
    input  logic [63:0]          sq,
    input  logic                 miss,
    input  vec_t                 o,
    input  vec_t                 d,
    input  logic [LIM_W-1:0]     near_l,
    input  logic [LIM_W-1:0]     far_l,
    output logic                 out_valid,
    output logic [TQW-1:0]       tq,
    output logic [DW-1:0]        dmag,
    output logic signed [LW-1:0] lo0_q,
    output logic signed [LW-1:0] lo1_q,
    output logic signed [LW-1:0] ld0_q,
    output logic signed [LW-1:0] ld1_q,
    output logic                 miss_q,
    output vec_t                 o_q,
    output vec_t                 d_q,
    output logic [LIM_W-1:0]     near_q,
    output logic [LIM_W-1:0]     far_q
);

    logic                 vs     [TQW+1];
    logic [LW-1:0]        rem_s  [TQW+1];
    logic [TQW-1:0]       num_s  [TQW+1];
    logic [TQW-1:0]       q_s    [TQW+1];
    logic [LW-1:0]        az_s   [TQW+1];
    logic [63:0]          sv_s   [TQW+1];
    logic [63:0]          sr_s   [TQW+1];
    logic signed [LW-1:0] lo0_s  [TQW+1];
    logic signed [LW-1:0] lo1_s  [TQW+1];
    logic signed [LW-1:0] ld0_s  [TQW+1];
    logic signed [LW-1:0] ld1_s  [TQW+1];
    logic                 miss_s [TQW+1];
    vec_t                 o_s    [TQW+1];
    vec_t                 d_s    [TQW+1];
    logic [LIM_W-1:0]     nr_s   [TQW+1];
    logic [LIM_W-1:0]     fr_s   [TQW+1];

    assign vs[0]     = in_valid;
    assign rem_s[0]  = rem0;
    assign num_s[0]  = numlo;
    assign q_s[0]    = '0;
    assign az_s[0]   = az;
    assign sv_s[0]   = sq;
    assign sr_s[0]   = '0;
    assign lo0_s[0]  = lo0;
    assign lo1_s[0]  = lo1;
    assign ld0_s[0]  = ld0;
    assign ld1_s[0]  = ld1;
    assign miss_s[0] = miss;
    assign o_s[0]    = o;
    assign d_s[0]    = d;
    assign nr_s[0]   = near_l;
    assign fr_s[0]   = far_l;

    for (genvar k = 0; k < TQW; k++)
    begin : g_step
        logic [LW:0]   trial;
        logic          ge;
        logic [63:0]   sv_next, sr_next;
        logic [LW-1:0] v_reg_unused;

        assign trial = {rem_s[k], num_s[k][TQW-1]};
        assign ge    = trial >= {1'b0, az_s[k]};
        assign v_reg_unused = '0;

        if (k < SQRT_STEPS)
        begin : g_sqrt
            localparam logic [63:0] BITC = 64'(1) << (62 - 2 * k);
            logic [63:0] rb;
            assign rb      = sr_s[k] + BITC;
            assign sv_next = (sv_s[k] >= rb) ? (sv_s[k] - rb) : sv_s[k];
            assign sr_next = (sv_s[k] >= rb) ? ((sr_s[k] >> 1) + BITC) : (sr_s[k] >> 1);
        end
        else
        begin : g_pass
            assign sv_next = sv_s[k];
            assign sr_next = sr_s[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vs[k+1] <= vs[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_s[k+1]  <= ge ? LW'(trial - {1'b0, az_s[k]}) : LW'(trial);
                num_s[k+1]  <= num_s[k] << 1;
                q_s[k+1]    <= {q_s[k][TQW-2:0], ge};
                az_s[k+1]   <= az_s[k] | v_reg_unused;
                sv_s[k+1]   <= sv_next;
                sr_s[k+1]   <= sr_next;
                lo0_s[k+1]  <= lo0_s[k];
                lo1_s[k+1]  <= lo1_s[k];
                ld0_s[k+1]  <= ld0_s[k];
                ld1_s[k+1]  <= ld1_s[k];
                miss_s[k+1] <= miss_s[k];
                o_s[k+1]    <= o_s[k];
                d_s[k+1]    <= d_s[k];
                nr_s[k+1]   <= nr_s[k];
                fr_s[k+1]   <= fr_s[k];
            end
        end
    end

    assign out_valid = vs[TQW];
    assign tq        = q_s[TQW];
    assign dmag      = sr_s[TQW][DW-1:0] | DW'(sv_s[TQW] & 64'd0) | DW'(rem_s[TQW] & '0)
                     | DW'(num_s[TQW] & '0);
    assign lo0_q     = lo0_s[TQW];
    assign lo1_q     = lo1_s[TQW];
    assign ld0_q     = ld0_s[TQW];
    assign ld1_q     = ld1_s[TQW];
    assign miss_q    = miss_s[TQW];
    assign o_q       = o_s[TQW];
    assign d_q       = d_s[TQW];
    assign near_q    = nr_s[TQW];
    assign far_q     = fr_s[TQW];

endmodule

### design/rdi_finish.sv
module rdi_finish
    import rdi_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int LW        = 50,
    parameter int TQW       = 49
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [TQW-1:0]       tq,
    input  logic [DW-1:0]        dmag,
    input  logic signed [LW-1:0] lo0,
    input  logic signed [LW-1:0] lo1,
    input  logic signed [LW-1:0] ld0,
    input  logic signed [LW-1:0] ld1,
    input  logic                 miss,
    input  vec_t                 o,
    input  vec_t                 d,
    input  logic [LIM_W-1:0]     near_l,
    input  logic [LIM_W-1:0]     far_l,
    output logic                 out_valid,
    output logic                 hit,
    output logic [LIM_W-1:0]     hit_distance,
    output vec_t                 hit_pos
);

    localparam int PDW = TQW + DW;
    localparam int PLW = TQW + LW;
    localparam int SW  = 2 * FRAC_BITS + 3;

    logic [LW-1:0]    ald0, ald1;
    logic [DW-1:0]    ad [3];
    logic [PDW-1:0]   pd;
    logic [PLW-1:0]   pl0, pl1;
    logic [PDW-1:0]   pw [3];

    logic                 v_reg [2];
    logic signed [LW-1:0] lo0_reg [2];
    logic signed [LW-1:0] lo1_reg [2];
    logic                 s0_reg [2];
    logic                 s1_reg [2];
    logic                 miss_reg [2];
    vec_t                 o_reg [2];
    logic [2:0]           sd_reg [2];
    logic [LIM_W-1:0]     n_reg [2];
    logic [LIM_W-1:0]     f_reg [2];

    logic                 v3_reg, miss3_reg;
    logic [LIM_W-1:0]     dist3_reg;
    logic [FRAC_BITS:0]   lpm0_reg, lpm1_reg;
    vec_t                 w3_reg;

    logic                 v4_reg, hit_reg;
    logic [LIM_W-1:0]     dist4_reg;
    vec_t                 w4_reg;

    logic [PDW-1:0]       dsh;
    logic [32:0]          dist33;
    logic [PLW-1:0]       lsh0, lsh1;
    logic [LW:0]          lt0, lt1;
    logic signed [LW+1:0] lp0, lp1;
    logic [LW+1:0]        lpa0, lpa1;
    logic signed [33:0]   ws [3];
    vec_t                 w_next;
    logic                 miss3_next;
    logic [SW-1:0]        ssum;

    always_comb
    begin
        ald0 = ld0[LW-1] ? LW'(-ld0) : LW'(ld0);
        ald1 = ld1[LW-1] ? LW'(-ld1) : LW'(ld1);
        for (int c = 0; c < 3; c++)
        begin
            ad[c] = d[c][DW-1] ? (~d[c] + 32'd1) : d[c];
        end
    end

    rdi_wmul #(.AW(TQW), .BW(DW)) u_mul_dist (.clk, .adv, .a(tq), .b(dmag), .p(pd));
    rdi_wmul #(.AW(TQW), .BW(LW)) u_mul_lx (.clk, .adv, .a(tq), .b(ald0), .p(pl0));
    rdi_wmul #(.AW(TQW), .BW(LW)) u_mul_ly (.clk, .adv, .a(tq), .b(ald1), .p(pl1));

    for (genvar c = 0; c < 3; c++)
    begin : g_wmul
        rdi_wmul #(.AW(TQW), .BW(DW)) u_mul_w (.clk, .adv, .a(tq), .b(ad[c]), .p(pw[c]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
            v_reg[1] <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            v_reg[1] <= v_reg[0];
            v3_reg   <= v_reg[1];
            v4_reg   <= v3_reg;
        end
    end

    always_comb
    begin
        dsh    = pd >> FRAC_BITS;
        dist33 = (dsh >= (PDW'(1) << 32)) ? {1'b1, 32'd0} : dsh[32:0];
        lsh0   = pl0 >> FRAC_BITS;
        lsh1   = pl1 >> FRAC_BITS;
        lt0    = (lsh0 >= (PLW'(1) << LW)) ? {1'b1, {LW{1'b0}}} : lsh0[LW:0];
        lt1    = (lsh1 >= (PLW'(1) << LW)) ? {1'b1, {LW{1'b0}}} : lsh1[LW:0];
        lp0    = s0_reg[1] ? ($signed({{2{lo0_reg[1][LW-1]}}, lo0_reg[1]}) - $signed({1'b0, lt0}))
                           : ($signed({{2{lo0_reg[1][LW-1]}}, lo0_reg[1]}) + $signed({1'b0, lt0}));
        lp1    = s1_reg[1] ? ($signed({{2{lo1_reg[1][LW-1]}}, lo1_reg[1]}) - $signed({1'b0, lt1}))
                           : ($signed({{2{lo1_reg[1][LW-1]}}, lo1_reg[1]}) + $signed({1'b0, lt1}));
        lpa0   = lp0[LW+1] ? (LW+2)'(-lp0) : (LW+2)'(lp0);
        lpa1   = lp1[LW+1] ? (LW+2)'(-lp1) : (LW+2)'(lp1);
        for (int c = 0; c < 3; c++)
        begin
            logic [PDW-1:0] wt;
            wt    = pw[c] >> FRAC_BITS;
            ws[c] = sd_reg[1][c] ? ($signed({{2{o_reg[1][c][DW-1]}}, o_reg[1][c]})
                                    - $signed({2'b00, wt[DW-1:0]}))
                                 : ($signed({{2{o_reg[1][c][DW-1]}}, o_reg[1][c]})
                                    + $signed({2'b00, wt[DW-1:0]}));
            if (ws[c][33:31] == 3'b000 || ws[c][33:31] == 3'b111)
            begin
                w_next[c] = ws[c][DW-1:0];
            end
            else
            begin
                w_next[c] = ws[c][33] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
        end
        miss3_next = miss_reg[1] || (dist33 < 33'(n_reg[1])) || (dist33 > 33'(f_reg[1]))
                  || (lpa0 > ((LW+2)'(1) << FRAC_BITS)) || (lpa1 > ((LW+2)'(1) << FRAC_BITS));
        ssum = SW'(lpm0_reg) * SW'(lpm0_reg) + SW'(lpm1_reg) * SW'(lpm1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo0_reg[0]  <= lo0;
            lo1_reg[0]  <= lo1;
            s0_reg[0]   <= ld0[LW-1];
            s1_reg[0]   <= ld1[LW-1];
            miss_reg[0] <= miss || (tq == '0);
            o_reg[0]    <= o;
            sd_reg[0]   <= {d[2][DW-1], d[1][DW-1], d[0][DW-1]};
            n_reg[0]    <= near_l;
            f_reg[0]    <= far_l;
            lo0_reg[1]  <= lo0_reg[0];
            lo1_reg[1]  <= lo1_reg[0];
            s0_reg[1]   <= s0_reg[0];
            s1_reg[1]   <= s1_reg[0];
            miss_reg[1] <= miss_reg[0];
            o_reg[1]    <= o_reg[0];
            sd_reg[1]   <= sd_reg[0];
            n_reg[1]    <= n_reg[0];
            f_reg[1]    <= f_reg[0];

            miss3_reg <= miss3_next;
            dist3_reg <= dist33[LIM_W-1:0];
            lpm0_reg  <= lpa0[FRAC_BITS:0];
            lpm1_reg  <= lpa1[FRAC_BITS:0];
            w3_reg    <= w_next;

            hit_reg   <= !(miss3_reg || (ssum > (SW'(1) << (2 * FRAC_BITS))));
            if (miss3_reg || (ssum > (SW'(1) << (2 * FRAC_BITS))))
            begin
                dist4_reg <= '0;
                w4_reg    <= '0;
            end
            else
            begin
                dist4_reg <= dist3_reg;
                w4_reg    <= w3_reg;
            end
        end
    end

    assign out_valid    = v4_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist4_reg;
    assign hit_pos      = w4_reg;

endmodule

### design/ray_disk_intersection_unit.sv
// Ray / unit disk intersection, one ray per clock while the pipe is not held.
//
// Ray channel: ray_valid / ray_stall with origin, direction and the near and
// far limits of one ray word. Result channel: res_valid / res_stall with hit,
// hit_distance and hit_x/y/z; a miss returns hit = 0 and all fields zero.
// Config channel: cfg_valid / cfg_ready (always ready) with cfg_index and
// cfg_data; write only while no ray is in flight.
//
// The pipe runs the matrix transform, then the one-bit-per-stage divider (the
// square root of |dir| runs in its first 32 stages), then the split wide
// multiply and last the clamp and circle test. Throughput is one ray word per
// cycle while res_stall does not hold the pipe.
//
// Reset clears all valid bits and loads the identity matrix and a parallel
// threshold of 7. When res_stall is high with a result pending, the whole
// pipe holds and ray_stall is raised in the same cycle; nothing is dropped.
module ray_disk_intersection_unit
    import rdi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ray_valid,
    output logic                 ray_stall,
    input  logic signed [DW-1:0] origin_x,
    input  logic signed [DW-1:0] origin_y,
    input  logic signed [DW-1:0] origin_z,
    input  logic signed [DW-1:0] dir_x,
    input  logic signed [DW-1:0] dir_y,
    input  logic signed [DW-1:0] dir_z,
    input  logic [LIM_W-1:0]     near_limit,
    input  logic [LIM_W-1:0]     far_limit,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic                 hit,
    output logic [LIM_W-1:0]     hit_distance,
    output logic signed [DW-1:0] hit_x,
    output logic signed [DW-1:0] hit_y,
    output logic signed [DW-1:0] hit_z
);

    localparam int LW  = 66 - FRAC_BITS;
    localparam int TQW = 33 + FRAC_BITS;
    localparam logic [CFG_DW-1:0] ONE = CFG_DW'(1) << FRAC_BITS;

    logic [CFG_DW-1:0] r0c01_reg, r0c23_reg, r1c01_reg, r1c23_reg, r2c01_reg, r2c23_reg;
    logic [MDZ_W-1:0]  mdz_reg;
    mat_t              m;
    logic              adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0c01_reg <= ONE;
            r0c23_reg <= '0;
            r1c01_reg <= ONE << 32;
            r1c23_reg <= '0;
            r2c01_reg <= '0;
            r2c23_reg <= ONE;
            mdz_reg   <= MDZ_W'(7);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_R0C01: r0c01_reg <= cfg_data;
                CFG_R0C23: r0c23_reg <= cfg_data;
                CFG_R1C01: r1c01_reg <= cfg_data;
                CFG_R1C23: r1c23_reg <= cfg_data;
                CFG_R2C01: r2c01_reg <= cfg_data;
                CFG_R2C23: r2c23_reg <= cfg_data;
                CFG_MDZ:   mdz_reg   <= cfg_data[MDZ_W-1:0];
                default:   ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m = {r2c23_reg, r2c01_reg, r1c23_reg, r1c01_reg, r0c23_reg, r0c01_reg};
    assign adv       = !res_valid || !res_stall;
    assign ray_stall = !adv;

    logic                 x_valid, x_miss;
    logic signed [LW-1:0] x_lo0, x_lo1, x_ld0, x_ld1;
    logic [LW-1:0]        x_az, x_rem0;
    logic [TQW-1:0]       x_numlo;
    logic [63:0]          x_sq;
    vec_t                 x_o, x_d;
    logic [LIM_W-1:0]     x_near, x_far;

    rdi_xform #(.FRAC_BITS(FRAC_BITS), .LW(LW), .TQW(TQW)) u_xform (
        .clk, .rst_n, .adv,
        .in_valid (ray_valid),
        .o        ({origin_z, origin_y, origin_x}),
        .d        ({dir_z, dir_y, dir_x}),
        .near_l   (near_limit),
        .far_l    (far_limit),
        .m        (m),
        .mdz      (mdz_reg),
        .out_valid(x_valid),
        .lo0(x_lo0), .lo1(x_lo1), .ld0(x_ld0), .ld1(x_ld1),
        .az(x_az), .rem0(x_rem0), .numlo(x_numlo), .sq(x_sq), .miss(x_miss),
        .o_q(x_o), .d_q(x_d), .near_q(x_near), .far_q(x_far)
    );

    logic                 s_valid, s_miss;
    logic [TQW-1:0]       s_tq;
    logic [DW-1:0]        s_dmag;
    logic signed [LW-1:0] s_lo0, s_lo1, s_ld0, s_ld1;
    vec_t                 s_o, s_d;
    logic [LIM_W-1:0]     s_near, s_far;

    rdi_solve #(.FRAC_BITS(FRAC_BITS), .LW(LW), .TQW(TQW)) u_solve (
        .clk, .rst_n, .adv,
        .in_valid(x_valid),
        .lo0(x_lo0), .lo1(x_lo1), .ld0(x_ld0), .ld1(x_ld1),
        .az(x_az), .rem0(x_rem0), .numlo(x_numlo), .sq(x_sq), .miss(x_miss),
        .o(x_o), .d(x_d), .near_l(x_near), .far_l(x_far),
        .out_valid(s_valid), .tq(s_tq), .dmag(s_dmag),
        .lo0_q(s_lo0), .lo1_q(s_lo1), .ld0_q(s_ld0), .ld1_q(s_ld1),
        .miss_q(s_miss), .o_q(s_o), .d_q(s_d), .near_q(s_near), .far_q(s_far)
    );

    vec_t pos;

    rdi_finish #(.FRAC_BITS(FRAC_BITS), .LW(LW), .TQW(TQW)) u_finish (
        .clk, .rst_n, .adv,
        .in_valid(s_valid), .tq(s_tq), .dmag(s_dmag),
        .lo0(s_lo0), .lo1(s_lo1), .ld0(s_ld0), .ld1(s_ld1),
        .miss(s_miss), .o(s_o), .d(s_d), .near_l(s_near), .far_l(s_far),
        .out_valid(res_valid), .hit(hit), .hit_distance(hit_distance), .hit_pos(pos)
    );

    assign hit_x = pos[0];
    assign hit_y = pos[1];
    assign hit_z = pos[2];

endmodule

### design/rdi_checker.sv
module rdi_checker
    import rdi_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 ray_valid,
    input logic                 ray_stall,
    input logic                 res_valid,
    input logic                 res_stall,
    input logic                 hit,
    input logic [LIM_W-1:0]     hit_distance,
    input logic signed [DW-1:0] hit_x,
    input logic signed [DW-1:0] hit_y,
    input logic signed [DW-1:0] hit_z
);

    // pending result word holds under stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(hit) && $stable(hit_distance)
            && $stable(hit_x) && $stable(hit_y) && $stable(hit_z))
        else $error("result word changed under stall");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> hit_distance == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0)
        else $error("miss with nonzero fields");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        ray_stall == (res_valid && res_stall))
        else $error("ray stall does not follow result stall");

    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

endmodule

bind ray_disk_intersection_unit rdi_checker u_rdi_checker (.*);

### bench/tb_ray_disk_intersection_unit.sv
module tb_ray_disk_intersection_unit;
    import rdi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint ONE = 64'h1_0000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 70;

    typedef struct {
        logic signed [DW-1:0] ox, oy, oz, dx, dy, dz;
        logic [LIM_W-1:0] near_l, far_l;
    } ray_t;

    typedef struct {
        logic hit;
        logic [LIM_W-1:0] hdist;
        logic signed [DW-1:0] px, py, pz;
    } hit_t;

    class hit_scoreboard;
        hit_t pending[$];
        int errors;

        function void note(hit_t e);
            pending.push_back(e);
        endfunction

        function void check(hit_t a);
            hit_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word hit=%0d dist=%h", $time, a.hit, a.hdist);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.hit !== e.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, e.hit, a.hit);
                errors++;
            end
            if (a.hdist !== e.hdist) begin
                $display("%0t: hit_distance expected %h actual %h", $time, e.hdist, a.hdist);
                errors++;
            end
            if (a.px !== e.px) begin
                $display("%0t: hit_x expected %h actual %h", $time, e.px, a.px);
                errors++;
            end
            if (a.py !== e.py) begin
                $display("%0t: hit_y expected %h actual %h", $time, e.py, a.py);
                errors++;
            end
            if (a.pz !== e.pz) begin
                $display("%0t: hit_z expected %h actual %h", $time, e.pz, a.pz);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic ray_valid = 1'b0;
    logic ray_stall;
    logic signed [DW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [DW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic [LIM_W-1:0] near_limit = '0, far_limit = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic hit;
    logic [LIM_W-1:0] hit_distance;
    logic signed [DW-1:0] hit_x, hit_y, hit_z;

    ray_disk_intersection_unit dut (.*);

    always #1 clk = ~clk;

    bit [63:0] regs [7];
    hit_scoreboard sb = new();
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    function automatic longint mat_entry(int r, int c);
        bit [63:0] w;
        w = regs[r * 2 + c / 2];
        return (c % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
    endfunction

    function automatic longint transform_row(int r, longint v0, longint v1, longint v2,
                                             bit with_t);
        longint hi, p;
        bit [63:0] lo;
        longint v [3];
        hi = 0;
        lo = 0;
        v[0] = v0;
        v[1] = v1;
        v[2] = v2;
        for (int c = 0; c < 3; c++) begin
            p = mat_entry(r, c) * v[c];
            hi += p >>> FB;
            lo += p & 64'hFFFF;
        end
        hi += longint'(lo >> FB);
        if (with_t)
            hi += mat_entry(r, 3);
        return hi;
    endfunction

    function automatic bit [63:0] magnitude(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic bit [63:0] mul_shift(bit [63:0] a, bit [63:0] b, bit [63:0] cap);
        bit [127:0] pr;
        pr = {64'b0, a} * {64'b0, b};
        pr = pr >> FB;
        if (pr[127:64] != 0)
            return cap;
        return pr[63:0] > cap ? cap : pr[63:0];
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint step_along(longint base, bit [63:0] t, longint v);
        longint p;
        p = longint'(mul_shift(t, magnitude(v), 64'd1 << 62));
        return base + (v < 0 ? -p : p);
    endfunction

    function automatic logic [DW-1:0] clamp32(longint x);
        if (x > 64'sh7FFF_FFFF)
            x = 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000)
            x = -64'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic hit_t predict_hit(ray_t r);
        hit_t res;
        longint o [3], d [3], lo [3], ld [3], lp [2];
        bit [63:0] az, tq, dmag, hdist, sq;
        res = '{hit: 1'b0, hdist: '0, px: '0, py: '0, pz: '0};
        o[0] = r.ox;
        o[1] = r.oy;
        o[2] = r.oz;
        d[0] = r.dx;
        d[1] = r.dy;
        d[2] = r.dz;
        for (int i = 0; i < 3; i++) begin
            lo[i] = transform_row(i, o[0], o[1], o[2], 1'b1);
            ld[i] = transform_row(i, d[0], d[1], d[2], 1'b0);
        end
        az = magnitude(ld[2]);
        if (ld[2] == 0 || az < 64'(regs[6][MDZ_W-1:0]))
            return res;
        if (lo[2] == 0 || ((lo[2] < 0) == (ld[2] < 0)))
            return res;
        tq = (magnitude(lo[2]) << FB) / az;
        if (tq == 0)
            return res;
        sq = 0;
        for (int i = 0; i < 3; i++)
            sq += magnitude(d[i]) * magnitude(d[i]);
        dmag = int_sqrt(sq);
        hdist = mul_shift(tq, dmag, 64'd1 << 32);
        if (hdist < 64'(r.near_l) || hdist > 64'(r.far_l))
            return res;
        for (int i = 0; i < 2; i++) begin
            lp[i] = step_along(lo[i], tq, ld[i]);
            if (magnitude(lp[i]) > ONE)
                return res;
        end
        if (magnitude(lp[0]) * magnitude(lp[0]) + magnitude(lp[1]) * magnitude(lp[1])
            > ONE * ONE)
            return res;
        res.hit = 1'b1;
        res.hdist = hdist[LIM_W-1:0];
        res.px = clamp32(step_along(o[0], tq, d[0]));
        res.py = clamp32(step_along(o[1], tq, d[1]));
        res.pz = clamp32(step_along(o[2], tq, d[2]));
        return res;
    endfunction

    // sample everything at the falling edge, where all signals have settled
    always @(negedge clk) begin
        ray_t r;
        hit_t a;
        if (rst_n && ray_valid && !ray_stall) begin
            r = '{ox: origin_x, oy: origin_y, oz: origin_z, dx: dir_x, dy: dir_y,
                  dz: dir_z, near_l: near_limit, far_l: far_limit};
            sb.note(predict_hit(r));
        end
        if (rst_n && res_valid && !res_stall) begin
            a = '{hit: hit, hdist: hit_distance, px: hit_x, py: hit_y, pz: hit_z};
            sb.check(a);
        end
    end

    always @(posedge clk) begin
        res_stall <= ($urandom_range(99) < stall_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_ray(ray_t r);
        bit taken;
        if ($urandom_range(99) < sender_idle_pct) begin
            ray_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        ray_valid <= 1'b1;
        origin_x <= r.ox;
        origin_y <= r.oy;
        origin_z <= r.oz;
        dir_x <= r.dx;
        dir_y <= r.dy;
        dir_z <= r.dz;
        near_limit <= r.near_l;
        far_limit <= r.far_l;
        do
        begin
            @(negedge clk);
            taken = ray_valid && !ray_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic wait_idle();
        ray_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [63:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        regs[idx] = (idx == CFG_MDZ) ? 64'(val[MDZ_W-1:0]) : val;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(bit [63:0] v [7]);
        wait_idle();
        write_reg(CFG_R0C01, v[0]);
        write_reg(CFG_R0C23, v[1]);
        write_reg(CFG_R1C01, v[2]);
        write_reg(CFG_R1C23, v[3]);
        write_reg(CFG_R2C01, v[4]);
        write_reg(CFG_R2C23, v[5]);
        write_reg(CFG_MDZ, v[6]);
    endtask

    function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                int nl, int fl);
        ray_t r;
        r = '{ox: ox, oy: oy, oz: oz, dx: dx, dy: dy, dz: dz,
              near_l: LIM_W'(nl), far_l: LIM_W'(fl)};
        return r;
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        if ($urandom_range(99) < 70) begin
            r.ox = int'($urandom_range(0, 32'h2_8000)) - 32'h1_4000;
            r.oy = int'($urandom_range(0, 32'h2_8000)) - 32'h1_4000;
            r.oz = $urandom_range(1, 32'h20_0000);
            r.dx = int'($urandom_range(0, 32'h1_0000)) - 32'h8000;
            r.dy = int'($urandom_range(0, 32'h1_0000)) - 32'h8000;
            r.dz = -int'($urandom_range(1, 32'h4_0000));
            if ($urandom_range(3) == 0)
                r.dz = -r.dz;
            r.near_l = LIM_W'(($urandom_range(3) == 0) ? $urandom_range(0, 32'h40_0000) : 0);
            r.far_l = LIM_W'(($urandom_range(3) == 0) ? $urandom_range(0, 32'h80_0000)
                                                      : 32'h7FFF_FFFF);
        end
        else begin
            r.ox = $urandom();
            r.oy = $urandom();
            r.oz = $urandom();
            r.dx = $urandom();
            r.dy = $urandom();
            r.dz = $urandom();
            r.near_l = LIM_W'($urandom());
            r.far_l = LIM_W'($urandom());
        end
        return r;
    endfunction

    task automatic random_rays(int n);
        for (int i = 0; i < n; i++) begin
            unique case ((i / 75) % 4)
                0: begin sender_idle_pct = 0; stall_pct = 0; end
                1: begin sender_idle_pct = 71; stall_pct = 0; end
                2: begin sender_idle_pct = 0; stall_pct = 71; end
                default: begin sender_idle_pct = 10; stall_pct = 10; end
            endcase
            send_ray(random_ray());
        end
    endtask

    initial begin
        bit [63:0] v [7];
        regs[0] = 64'h1_0000;
        regs[1] = 64'd0;
        regs[2] = 64'h1_0000 << 32;
        regs[3] = 64'd0;
        regs[4] = 64'd0;
        regs[5] = 64'h1_0000;
        regs[6] = 64'd7;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity matrix, default threshold
        send_ray(mk(0, 0, 32'h5_0000, 0, 0, -32'h1_0000, 0, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 32'h5_0000, 32'h1_0000, 0, 0, 0, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 32'h5_0000, 0, 0, -3, 0, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 32'h5_0000, 0, 0, -7, 0, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 0, 0, 0, -32'h1_0000, 0, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 32'h5_0000, 0, 0, 32'h1_0000, 0, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 1, 0, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF));
        send_ray(mk(32'h1_0001, 0, 32'h1_0000, 0, 0, -32'h1_0000, 0, 32'h7FFF_FFFF));
        send_ray(mk(32'h1_0000, 0, 32'h1_0000, 0, 0, -32'h1_0000, 0, 32'h7FFF_FFFF));
        send_ray(mk(32'hB505, 32'hB505, 32'h1_0000, 0, 0, -32'h1_0000, 0, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 32'h5_0000, 0, 0, -32'h1_0000, 32'h5_0001, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 32'h5_0000, 0, 0, -32'h1_0000, 0, 32'h4_FFFF));
        send_ray(mk(0, 0, 32'h5_0000, 0, 0, -32'h1_0000, 32'h5_0000, 32'h5_0000));
        send_ray(mk(0, 0, 32'h7FFF_FFFF, 0, 0, -1, 0, 32'h7FFF_FFFF));
        send_ray(mk(-32'h8000, 32'h8000, -32'h3_0000, 32'h2000, 0, 32'h1_0000, 0,
                    32'h7FFF_FFFF));
        send_ray(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        send_ray(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF));
        random_rays(280);

        // half scale with translation, zero threshold
        v = '{64'h0_8000, 64'h0_8000_0000_0000, 64'h8000 << 32, 64'd0, 64'd0,
              {32'h1_0000, 32'h8000}, 64'd0};
        load_config(v);
        random_rays(300);

        // tiny scale in x and y so world positions saturate
        v = '{64'h1, 64'd0, 64'h1 << 32, 64'd0, 64'd0, 64'h1_0000, 64'h1_0000};
        load_config(v);
        send_ray(mk(32'h7FFF_0000, 0, 32'h1_0000, 32'h7FFF_0000, 0, -32'h1_0000, 0,
                    32'h7FFF_FFFF));
        send_ray(mk(-32'h7FFF_0000, 0, 32'h1_0000, -32'h7FFF_0000, 0, -32'h1_0000, 0,
                    32'h7FFF_FFFF));
        send_ray(mk(0, 0, 32'h1_0000, 0, 0, -32'hFFFF, 0, 32'h7FFF_FFFF));
        random_rays(300);

        // x/y swap with mirrored z
        v = '{64'h1_0000 << 32, 64'd0, 64'h1_0000, 64'd0, 64'd0, 64'hFFFF_0000, 64'd7};
        load_config(v);
        random_rays(300);

        // every matrix entry all ones
        v = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h1_0000};
        load_config(v);
        random_rays(300);

        v = '{{$urandom(), $urandom()}, {$urandom(), $urandom()}, {$urandom(), $urandom()},
              {$urandom(), $urandom()}, {$urandom(), $urandom()}, {$urandom(), $urandom()},
              64'($urandom_range(0, 32'h1_0000))};
        load_config(v);
        random_rays(300);

        wait_idle();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
design/rdi_pkg.sv
design/rdi_wmul.sv
design/rdi_xform.sv
design/rdi_solve.sv
design/rdi_finish.sv
design/ray_disk_intersection_unit.sv
design/rdi_checker.sv
bench/tb_ray_disk_intersection_unit.sv
